[rtl/tsnp_pkg.sv]
package tsnp_pkg;

  localparam int STOP_W = 16;
  localparam int POS_W  = 17;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [STOP_W-1:0] STOP_LIMIT      = 16'hFFFF;
  localparam logic [STOP_W-1:0] INTERVAL_RESET  = 16'd8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_ASC  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_FINAL,
    ST_DIV
  } tsnp_state_t;

  // request into the divider
  typedef struct packed {
    logic              go;
    logic [STOP_W-1:0] dividend;
    logic [STOP_W-1:0] divisor;
  } tsnp_div_req_t;

endpackage

[rtl/tab_stop_next_position_core.sv]
// Tab stop table with next-tab lookup. Each request (start high while busy is
// low) gives exactly one result, shown for a single cycle with out_valid high;
// the receiver cannot stall, so it must take every result in that cycle.
// Clear and append keep busy low, so they may be issued back to back. A
// query that hits the table runs a binary search over the stop memory (one
// write port, one read port): each halving step is a read state and a compare
// state, then a final read and the result state. A query on an empty table or
// past the last stop runs the 16-bit restoring divider, one bit per cycle.
// busy is high for the whole of a query. cfg_wdata sets the repeat interval
// (reset 8, zero acts as one); the user must write it only while idle, as the
// block itself does not enforce this.
module tab_stop_next_position_core #(
  parameter int MAX_STOPS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsnp_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tsnp_pkg::STOP_W-1:0]   in_value,
  input  logic                          cfg_we,
  input  logic [tsnp_pkg::STOP_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic [tsnp_pkg::POS_W-1:0]    out_next_position,
  output logic [tsnp_pkg::STAT_W-1:0]   out_status
);
  import tsnp_pkg::*;

  localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int CNT_W = $clog2(MAX_STOPS + 1);

  // state and registers
  tsnp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STOP_W-1:0] last_r, last_nxt;
  logic [STOP_W-1:0] interval_r;
  logic [STOP_W-1:0] col_r, col_nxt;
  logic [STOP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic              valid_r, valid_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  // datapath helpers
  logic              accept;
  logic              is_query;
  logic              use_repeat;
  logic [IDX_W-1:0]  mid;
  logic [STOP_W-1:0] step_eff;

  // memory and divider hookup
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [STOP_W-1:0] mem_rdata;
  tsnp_div_req_t     div_req;
  logic              div_done;
  logic [STOP_W-1:0] div_rem;

  assign accept     = start && (state_r == ST_IDLE);
  assign is_query   = (in_cmd == CMD_QUERY);
  assign use_repeat = (count_r == '0) || (in_value > last_r);
  assign mid        = lo_r + IDX_W'((hi_r - lo_r) >> 1);
  assign step_eff   = (interval_r == '0) ? STOP_W'(1) : interval_r;

  tsnp_stop_mem #(
    .DEPTH (MAX_STOPS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tsnp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .rem   (div_rem)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = use_repeat ? ST_DIV : ST_SRCH;
        end
      end
      ST_SRCH: begin
        state_nxt = (lo_r < hi_r) ? ST_CMP : ST_FINAL;
      end
      ST_CMP: begin
        state_nxt = ST_SRCH;
      end
      ST_FINAL: begin
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    count_nxt = count_r;
    last_nxt  = last_r;
    col_nxt   = col_r;
    step_nxt  = step_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    valid_nxt = 1'b0;
    pos_nxt   = pos_r;
    stat_nxt  = stat_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = lo_r;
    div_req   = '{go: 1'b0, dividend: in_value, divisor: step_eff};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_nxt  = in_value;
          step_nxt = step_eff;
          lo_nxt   = '0;
          hi_nxt   = CNT_W'(count_r - 1'b1) > CNT_W'(0) ?
                     IDX_W'(CNT_W'(count_r - 1'b1)) : '0;
          case (in_cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              last_nxt  = '0;
              valid_nxt = 1'b1;
              pos_nxt   = '0;
              stat_nxt  = STAT_OK;
            end
            CMD_APPEND: begin
              valid_nxt = 1'b1;
              pos_nxt   = '0;
              if (in_value == '0 || in_value == STOP_LIMIT) begin
                stat_nxt = STAT_RANGE;
              end else if (in_value <= last_r) begin
                stat_nxt = STAT_NOT_ASC;
              end else if (count_r == CNT_W'(MAX_STOPS)) begin
                stat_nxt = STAT_FULL;
              end else begin
                stat_nxt  = STAT_OK;
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                last_nxt  = in_value;
              end
            end
            CMD_QUERY: begin
              // empty table or past the last stop goes to the divider
              div_req.go = use_repeat;
            end
            default: begin
              valid_nxt = 1'b1;
              pos_nxt   = '0;
              stat_nxt  = STAT_OK;
            end
          endcase
        end
      end
      ST_SRCH: begin
        mem_re    = 1'b1;
        mem_raddr = (lo_r < hi_r) ? mid : lo_r;
      end
      ST_CMP: begin
        // mid is still the address read last cycle, lo and hi have not moved
        if (mem_rdata >= col_r) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 1'b1;
        end
      end
      ST_FINAL: begin
        valid_nxt = 1'b1;
        pos_nxt   = {1'b0, mem_rdata};
        stat_nxt  = STAT_OK;
      end
      ST_DIV: begin
        if (div_done) begin
          // (col / step + 1) * step is col - rem + step
          valid_nxt = 1'b1;
          pos_nxt   = {1'b0, col_r} - {1'b0, div_rem} + {1'b0, step_r};
          stat_nxt  = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      last_r     <= '0;
      interval_r <= INTERVAL_RESET;
      valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    step_r <= step_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = valid_r;
  assign out_next_position = pos_r;
  assign out_status        = stat_r;

endmodule

[rtl/tsnp_stop_mem.sv]
module tsnp_stop_mem #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [tsnp_pkg::STOP_W-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [tsnp_pkg::STOP_W-1:0] rdata
);
  import tsnp_pkg::*;

  logic [STOP_W-1:0] mem [DEPTH];
  logic [STOP_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tsnp_div.sv]
module tsnp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsnp_pkg::tsnp_div_req_t       req,
  output logic                          done,
  output logic [tsnp_pkg::STOP_W-1:0]   rem
);
  import tsnp_pkg::*;

  localparam int CNT_W = $clog2(STOP_W + 1);

  logic [STOP_W-1:0] dvd_r, dvd_nxt;
  logic [STOP_W-1:0] dsr_r, dsr_nxt;
  logic [STOP_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic [STOP_W:0]   trial;

  // restoring division, one quotient bit per cycle; only the remainder is kept
  always_comb begin
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial   = {rem_r, dvd_r[STOP_W-1]};
    if (req.go) begin
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(STOP_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r != '0) begin
        dvd_nxt = {dvd_r[STOP_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr_r}) begin
          rem_nxt = STOP_W'(trial - {1'b0, dsr_r});
        end else begin
          rem_nxt = trial[STOP_W-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = run_r && (cnt_r == '0);
  assign rem  = rem_r;

endmodule

[tb/sv/tab_stop_next_position_core_test.sv]
module tab_stop_next_position_core_test;
  import tsnp_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int SETTLE_CYCLES = 24;    // longer than the slowest query
  localparam int PRINT_CAP     = 40;
  localparam int QUIET_FROM    = 500;   // stretch of requests sent with no gaps at all
  localparam int QUIET_TO      = 760;

  // unused command code, must leave the table alone and answer zero
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
  } tab_answer_t;

  // one row of the directed plan: either a repeat interval write or a run of requests
  typedef struct packed {
    bit                is_cfg;
    logic [CMD_W-1:0]  cmd;
    logic [STOP_W-1:0] value;
    int                reps;
    int                stride;
    bit                typed;
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] status;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd;
  logic [STOP_W-1:0]   in_value;
  logic                cfg_we;
  logic [STOP_W-1:0]   cfg_wdata;
  logic                out_valid;
  logic [POS_W-1:0]    out_next_position;
  logic [STAT_W-1:0]   out_status;

  // predictor copy of the block state
  logic [STOP_W-1:0]   stop_list [TABLE_DEPTH];
  int unsigned         stop_total;
  logic [STOP_W-1:0]   final_stop;
  logic [STOP_W-1:0]   tab_interval;

  // answers still owed by the block, oldest first
  tab_answer_t         pending_answers [$];

  // typed-in answer travelling with the request being driven
  bit                  drv_typed;
  tab_answer_t         drv_answer;

  int                  fail_count;
  int                  sent_count;
  int                  answers_seen;
  int                  query_count;
  int                  refused_count;

  tab_stop_next_position_core #(
    .MAX_STOPS (TABLE_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_value          (in_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_next_position (out_next_position),
    .out_status        (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // next tab column for one request, updating the predictor state on the way
  function automatic void predict_answer(input logic [CMD_W-1:0] cmd,
                                         input logic [STOP_W-1:0] col,
                                         output tab_answer_t answer);
    int unsigned step;
    bit          found;
    answer = '0;
    found  = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        // table contents are kept, only the count and last stop go
        stop_total = 0;
        final_stop = '0;
      end
      CMD_APPEND: begin
        // range first, then order, then room
        if (col == '0 || col >= STOP_LIMIT) begin
          answer.status = STAT_RANGE;
        end else if (col <= final_stop) begin
          answer.status = STAT_NOT_ASC;
        end else if (stop_total >= TABLE_DEPTH) begin
          answer.status = STAT_FULL;
        end else begin
          stop_list[stop_total] = col;
          stop_total++;
          final_stop = col;
        end
        if (answer.status != STAT_OK) begin
          refused_count++;
        end
      end
      CMD_QUERY: begin
        query_count++;
        if (stop_total == 0 || col > final_stop) begin
          // default stops: next multiple strictly above, interval zero acts as one
          step = (tab_interval == '0) ? 1 : tab_interval;
          answer.position = POS_W'((col / step + 1) * step);
        end else begin
          // first listed stop at or after the column
          for (int k = 0; k < stop_total; k++) begin
            if (!found && stop_list[k] >= col) begin
              answer.position = {1'b0, stop_list[k]};
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // predictor and checker, both on the rising edge
  always @(posedge clk) begin
    tab_answer_t fresh;
    tab_answer_t want;
    if (!rst_n) begin
      stop_total   = 0;
      final_stop   = '0;
      tab_interval = INTERVAL_RESET;
    end else begin
      if (cfg_we) begin
        tab_interval = cfg_wdata;
      end
      // request taken this edge: predict before looking at the result port
      if (start && !busy) begin
        predict_answer(in_cmd, in_value, fresh);
        if (drv_typed) begin
          fresh = drv_answer;
        end
        pending_answers.push_back(fresh);
      end
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result, next position %0d status %0d",
                                    out_next_position, out_status));
        end else begin
          want = pending_answers.pop_front();
          answers_seen++;
          if (out_next_position !== want.position) begin
            report_mismatch($sformatf("next position %0d, expected %0d",
                                      out_next_position, want.position));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          end
        end
      end
    end
  end

  // entered and left just after a falling edge; start stays high on return
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [STOP_W-1:0] value,
                              input bit typed, input tab_answer_t answer);
    bit gaps_on;
    gaps_on = !(sent_count >= QUIET_FROM && sent_count < QUIET_TO);
    if (gaps_on) begin
      while ($urandom_range(99) < 30) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_value   <= value;
    drv_typed  <= typed;
    drv_answer <= answer;
    // busy seen here is its value just before the edge, same as the block sees it
    do @(posedge clk); while (busy);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [CMD_W-1:0] cmd, input logic [STOP_W-1:0] value);
    send_request(cmd, value, 1'b0, '0);
  endtask

  // repeat interval only changes once the block has drained
  task automatic write_interval(input logic [STOP_W-1:0] interval);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= interval;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // query column near a listed stop, just past the last one, at an extreme or anywhere
  function automatic logic [STOP_W-1:0] pick_column();
    int c;
    int mode;
    int k;
    mode = $urandom_range(9);
    if (stop_total != 0 && mode < 6) begin
      k = $urandom_range(stop_total - 1);
      c = int'(stop_list[k]) + int'($urandom_range(4)) - 2;
    end else if (mode == 6) begin
      c = int'(final_stop) + int'($urandom_range(20));
    end else if (mode == 7) begin
      c = ($urandom_range(1) == 0) ? 0 : 65535;
    end else begin
      c = $urandom_range(65535);
    end
    if (c < 0) c = 0;
    if (c > 65535) c = 65535;
    return STOP_W'(c);
  endfunction

  // mostly clear / ascending appends / queries, with broken appends and noise mixed in
  task automatic run_random(input int goal);
    int stop_at;
    int prev;
    int c;
    int count;
    int cap;
    int nq;
    stop_at = sent_count + goal;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) != 0) begin
          send_plain(CMD_CLEAR, STOP_W'($urandom));
          prev = 0;
        end else begin
          prev = final_stop;
        end
        // now and then enough appends to run the table full
        count = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        case ($urandom_range(2))
          0:       cap = 8;
          1:       cap = 1800;
          default: cap = 20000;
        endcase
        if (count > 20 && cap > 1800) cap = 1800;
        for (int k = 0; k < count; k++) begin
          if ($urandom_range(11) == 0) begin
            c = $urandom_range(prev);          // zero or out of order
          end else begin
            c = prev + $urandom_range(1, cap);
          end
          if (c > 65535) c = 65535;
          send_plain(CMD_APPEND, STOP_W'(c));
          if (c > prev) prev = c;
        end
        nq = $urandom_range(3, 10);
        for (int k = 0; k < nq; k++) begin
          send_plain(CMD_QUERY, pick_column());
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          send_plain(CMD_W'($urandom_range(3)), STOP_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    plan_row_t   plan [31];
    tab_answer_t typed_answer;
    logic [STOP_W-1:0] phase_interval [6];
    int          settle;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_cmd     = CMD_CLEAR;
    in_value   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    drv_typed  = 1'b0;
    drv_answer = '0;

    //        cfg   cmd         value     reps stride typed position    status
    plan = '{
      '{1'b0, CMD_QUERY,  16'd0,     1,  0,   1'b1, 17'd8,      STAT_OK},      // empty table
      '{1'b0, CMD_QUERY,  16'd65535, 1,  0,   1'b1, 17'd65536,  STAT_OK},
      '{1'b0, CMD_APPEND, 16'd0,     1,  0,   1'b1, 17'd0,      STAT_RANGE},   // zero stop
      '{1'b0, CMD_APPEND, 16'd65535, 1,  0,   1'b1, 17'd0,      STAT_RANGE},   // too big
      '{1'b0, CMD_APPEND, 16'd1,     1,  0,   1'b1, 17'd0,      STAT_OK},
      '{1'b0, CMD_APPEND, 16'd1,     1,  0,   1'b1, 17'd0,      STAT_NOT_ASC}, // equal
      '{1'b0, CMD_APPEND, 16'd9,     1,  0,   1'b1, 17'd0,      STAT_OK},
      '{1'b0, CMD_APPEND, 16'd5,     1,  0,   1'b1, 17'd0,      STAT_NOT_ASC}, // below
      '{1'b0, CMD_QUERY,  16'd0,     1,  0,   1'b1, 17'd1,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd2,     1,  0,   1'b0, 17'd0,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd9,     1,  0,   1'b1, 17'd9,      STAT_OK},      // on last stop
      '{1'b0, CMD_QUERY,  16'd10,    1,  0,   1'b0, 17'd0,      STAT_OK},      // past last stop
      '{1'b0, CMD_NOP,    16'hFFFF,  1,  0,   1'b1, 17'd0,      STAT_OK},
      '{1'b0, CMD_CLEAR,  16'hFFFF,  1,  0,   1'b1, 17'd0,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd5,     1,  0,   1'b1, 17'd8,      STAT_OK},      // cleared
      '{1'b0, CMD_APPEND, 16'd100,   32, 100, 1'b0, 17'd0,      STAT_OK},      // fill up
      '{1'b0, CMD_APPEND, 16'd65534, 1,  0,   1'b1, 17'd0,      STAT_FULL},
      '{1'b0, CMD_APPEND, 16'd0,     1,  0,   1'b1, 17'd0,      STAT_RANGE},   // range beats full
      '{1'b0, CMD_APPEND, 16'd3200,  1,  0,   1'b1, 17'd0,      STAT_NOT_ASC}, // order beats full
      '{1'b0, CMD_QUERY,  16'd3200,  1,  0,   1'b1, 17'd3200,   STAT_OK},
      '{1'b0, CMD_QUERY,  16'd1550,  1,  0,   1'b0, 17'd0,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd3201,  1,  0,   1'b0, 17'd0,      STAT_OK},
      '{1'b1, CMD_CLEAR,  16'd0,     1,  0,   1'b0, 17'd0,      STAT_OK},      // interval zero
      '{1'b0, CMD_QUERY,  16'd3201,  1,  0,   1'b1, 17'd3202,   STAT_OK},
      '{1'b0, CMD_QUERY,  16'd65535, 1,  0,   1'b1, 17'd65536,  STAT_OK},
      '{1'b1, CMD_CLEAR,  16'd65535, 1,  0,   1'b0, 17'd0,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd65535, 1,  0,   1'b1, 17'd131070, STAT_OK},
      '{1'b0, CMD_QUERY,  16'd65534, 1,  0,   1'b1, 17'd65535,  STAT_OK},
      '{1'b1, CMD_CLEAR,  16'd65534, 1,  0,   1'b0, 17'd0,      STAT_OK},
      '{1'b0, CMD_QUERY,  16'd65535, 1,  0,   1'b1, 17'd131068, STAT_OK},
      '{1'b0, CMD_QUERY,  16'd101,   1,  0,   1'b0, 17'd0,      STAT_OK}
    };

    // intervals for the random phases, extremes included
    phase_interval[0] = INTERVAL_RESET;
    phase_interval[1] = 16'd1;
    phase_interval[2] = 16'd65534;
    phase_interval[3] = 16'd0;
    phase_interval[4] = 16'd65535;
    phase_interval[5] = STOP_W'($urandom_range(2, 300));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_interval(plan[r].value);
      end else begin
        typed_answer.position = plan[r].position;
        typed_answer.status   = plan[r].status;
        for (int k = 0; k < plan[r].reps; k++) begin
          send_request(plan[r].cmd, plan[r].value + STOP_W'(k * plan[r].stride),
                       plan[r].typed, typed_answer);
        end
      end
    end

    // random part, one interval setting per phase
    foreach (phase_interval[p]) begin
      write_interval(phase_interval[p]);
      run_random(RANDOM_ITEMS / 6);
    end

    // drain, then let any stray result show up
    start <= 1'b0;
    settle = 0;
    while (pending_answers.size() != 0 && settle < 1000) begin
      @(negedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    end

    $display("ran %0d requests (%0d queries, %0d refused appends), %0d results checked",
             sent_count, query_count, refused_count, answers_seen);
    $display("repeat intervals 0, 1, 8, 65534, 65535 and one random value were exercised");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[tab_stop_next_position_core.f]
rtl/tsnp_pkg.sv
rtl/tsnp_stop_mem.sv
rtl/tsnp_div.sv
rtl/tab_stop_next_position_core.sv
tb/sv/tab_stop_next_position_core_test.sv
